// File: design/sipt_pkg.sv
// Shared types for the segment intersection point pipeline.
// No dependencies.
`timescale 1ns / 1ps

package sipt_pkg;

   // Per-item control flags that ride along with the datapath
   typedef struct packed {
      logic valid;
      logic det_zero;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } sipt_flags_type;

endpackage

// File: design/sipt_req_if.sv
// Request and response channel interfaces for the intersection block.
// Depends on nothing; widths come from interface parameters.
`timescale 1ns / 1ps

interface sipt_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_start_x;
   logic signed [COORD_BITS-1:0] first_start_y;
   logic signed [COORD_BITS-1:0] first_end_x;
   logic signed [COORD_BITS-1:0] first_end_y;
   logic signed [COORD_BITS-1:0] second_start_x;
   logic signed [COORD_BITS-1:0] second_start_y;
   logic signed [COORD_BITS-1:0] second_end_x;
   logic signed [COORD_BITS-1:0] second_end_y;

   modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                   second_start_x, second_start_y, second_end_x, second_end_y,
                   input ready);
   modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                 second_start_x, second_start_y, second_end_x, second_end_y,
                 output ready);
endinterface

interface sipt_rsp_if #(parameter int OUT_BITS = 32);
   logic                       valid;
   logic                       ready;
   logic                       meets;
   logic signed [OUT_BITS-1:0] cross_x;
   logic signed [OUT_BITS-1:0] cross_y;

   modport source (output valid, meets, cross_x, cross_y, input ready);
   modport sink (input valid, meets, cross_x, cross_y, output ready);
endinterface

// File: design/segment_intersection_point_top.sv
// Top level of the segment intersection point pipeline.
// Depends on sipt_pkg, sipt_req_if, sipt_rsp_if, sipt_front, sipt_cell.
`timescale 1ns / 1ps
//
// Usage:
//   req carries two segments as eight signed COORD_BITS-wide endpoint coordinates.
//   rsp returns meets plus the intersection point in signed fixed point with
//   FRAC_BITS fraction bits, truncated toward zero; both coordinates are 0
//   when meets is 0 (parallel, collinear or degenerate pairs, or a point
//   outside either segment's bounding box, or a quotient too large to fit).
//   Throughput: one transfer per cycle on each side while rsp is not stalled.
//   Pipeline: front-end stages (products, determinant, numerators, seed),
//   then COORD_BITS+FRAC_BITS+1 divider cells, one quotient bit each, then
//   one output register.
//   The divider chain length sets the latency.
//   Reset is synchronous and clears all valid bits; no result is pending
//   afterwards. When rsp is stalled, the whole pipeline holds and req.ready
//   falls, so no item is lost; the output register keeps its transfer.

module segment_intersection_point_top
   import sipt_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic   clock,
   input  logic   reset,
   sipt_req_if.sink   req,
   sipt_rsp_if.source rsp
);

   localparam int C  = COORD_BITS;
   localparam int QW = C+FRAC_BITS+1;
   localparam int OW = C+FRAC_BITS;
   localparam int DW = 2*C+2;
   localparam int NM = 3*C+2;

   logic en;
   logic rsp_valid_ff;

   // global advance: stall only when the output register is full and held
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   sipt_flags_type       fl   [QW+1];
   logic [DW-1:0]        dm   [QW+1];
   logic [DW-1:0]        rx   [QW+1];
   logic [DW-1:0]        ry   [QW+1];
   logic [NM-1:0]        nx   [QW+1];
   logic [NM-1:0]        ny   [QW+1];
   logic [QW-1:0]        qx   [QW+1];
   logic [QW-1:0]        qy   [QW+1];
   logic [8*C-1:0]       bd   [QW+1];

   sipt_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req.valid),
      .x1(req.first_start_x), .y1(req.first_start_y),
      .x2(req.first_end_x), .y2(req.first_end_y),
      .x3(req.second_start_x), .y3(req.second_start_y),
      .x4(req.second_end_x), .y4(req.second_end_y),
      .flags(fl[0]), .dmag(dm[0]), .rem_x(rx[0]), .rem_y(ry[0]),
      .nmag_x(nx[0]), .nmag_y(ny[0]), .bnd(bd[0])
   );

   assign qx[0] = '0;
   assign qy[0] = '0;

   // divider chain
   generate
      for (genvar i = 0; i < QW; i++) begin : g_cell
         sipt_cell #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .IDX(i)) u_cell (
            .clock(clock), .reset(reset), .en(en),
            .flags_i(fl[i]), .dmag_i(dm[i]), .rem_x_i(rx[i]), .rem_y_i(ry[i]),
            .nmag_x_i(nx[i]), .nmag_y_i(ny[i]), .q_x_i(qx[i]), .q_y_i(qy[i]),
            .bnd_i(bd[i]),
            .flags_o(fl[i+1]), .dmag_o(dm[i+1]), .rem_x_o(rx[i+1]), .rem_y_o(ry[i+1]),
            .nmag_x_o(nx[i+1]), .nmag_y_o(ny[i+1]), .q_x_o(qx[i+1]), .q_y_o(qy[i+1]),
            .bnd_o(bd[i+1])
         );
      end
   endgenerate

   // sign, box test
   sipt_flags_type        fe;
   logic signed [QW:0]    px, py;
   logic signed [C-1:0]   xlo1, xhi1, xlo2, xhi2, ylo1, yhi1, ylo2, yhi2;
   logic signed [OW-1:0]  sxlo1, sxhi1, sxlo2, sxhi2, sylo1, syhi1, sylo2, syhi2;
   logic                  hit;

   always_comb begin
      fe = fl[QW];
      {xlo1, xhi1, xlo2, xhi2, ylo1, yhi1, ylo2, yhi2} = bd[QW];
      px = fe.neg_x ? -$signed({1'b0, qx[QW]}) : $signed({1'b0, qx[QW]});
      py = fe.neg_y ? -$signed({1'b0, qy[QW]}) : $signed({1'b0, qy[QW]});
      sxlo1 = OW'(xlo1) <<< FRAC_BITS;
      sxhi1 = OW'(xhi1) <<< FRAC_BITS;
      sxlo2 = OW'(xlo2) <<< FRAC_BITS;
      sxhi2 = OW'(xhi2) <<< FRAC_BITS;
      sylo1 = OW'(ylo1) <<< FRAC_BITS;
      syhi1 = OW'(yhi1) <<< FRAC_BITS;
      sylo2 = OW'(ylo2) <<< FRAC_BITS;
      syhi2 = OW'(yhi2) <<< FRAC_BITS;
      hit = !fe.det_zero && !fe.ovf_x && !fe.ovf_y
            && px >= sxlo1 && px <= sxhi1 && px >= sxlo2 && px <= sxhi2
            && py >= sylo1 && py <= syhi1 && py >= sylo2 && py <= syhi2;
   end

   // output register
   logic                 meets_ff;
   logic signed [OW-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fe.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meets_ff <= hit;
         cx_ff    <= hit ? px[OW-1:0] : '0;
         cy_ff    <= hit ? py[OW-1:0] : '0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.meets   = meets_ff;
   assign rsp.cross_x = cx_ff;
   assign rsp.cross_y = cy_ff;

   // checks
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.meets |-> rsp.cross_x == '0 && rsp.cross_y == '0)
      else $error("miss result carries a nonzero point");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.cross_x) && $stable(rsp.meets))
      else $error("held result changed during stall");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input taken while pipeline stalled");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");

endmodule

// File: design/sipt_front.sv
// Front end: differences, determinant, numerators, magnitudes, divider seed.
// Depends on sipt_pkg.
`timescale 1ns / 1ps

module sipt_front
   import sipt_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [COORD_BITS-1:0]   x1, y1, x2, y2, x3, y3, x4, y4,
   output sipt_flags_type                 flags,
   output logic [2*COORD_BITS+1:0]        dmag,
   output logic [2*COORD_BITS+1:0]        rem_x,
   output logic [2*COORD_BITS+1:0]        rem_y,
   output logic [3*COORD_BITS+1:0]        nmag_x,
   output logic [3*COORD_BITS+1:0]        nmag_y,
   output logic [8*COORD_BITS-1:0]        bnd
);

   localparam int C  = COORD_BITS;
   localparam int DW = 2*C+2;   // |det|
   localparam int NW = 3*C+3;   // signed numerator
   localparam int NM = NW-1;    // numerator magnitude

   // stage 1: differences, first products, bounding boxes
   logic [3:0] v_ff, v_in;
   logic signed [C:0]     dx12_ff, dy12_ff, dx34_ff, dy34_ff;
   logic signed [2*C+1:0] pa_ff, pb_ff;
   logic signed [2*C-1:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic [8*C-1:0]        b1_ff, b2_ff, b3_ff, b4_ff, b5_ff;
   logic signed [C:0]     dx12_in, dy12_in, dx34_in, dy34_in;

   function automatic logic [2*COORD_BITS-1:0] minmax(input logic signed [COORD_BITS-1:0] a,
                                                      input logic signed [COORD_BITS-1:0] b);
      logic [2*COORD_BITS-1:0] r;
      if (a < b) r = {a, b};
      else r = {b, a};
      return r;
   endfunction

   always_comb begin
      dx12_in = (C+1)'(x1) - (C+1)'(x2);
      dy12_in = (C+1)'(y1) - (C+1)'(y2);
      dx34_in = (C+1)'(x3) - (C+1)'(x4);
      dy34_in = (C+1)'(y3) - (C+1)'(y4);
   end

   // bnd layout: {xlo1,xhi1,xlo2,xhi2,ylo1,yhi1,ylo2,yhi2}
   always_ff @(posedge clock) begin
      if (en) begin
         dx12_ff <= dx12_in;
         dy12_ff <= dy12_in;
         dx34_ff <= dx34_in;
         dy34_ff <= dy34_in;
         pa_ff   <= (2*C+2)'(dx12_in) * (2*C+2)'(dy34_in);
         pb_ff   <= (2*C+2)'(dy12_in) * (2*C+2)'(dx34_in);
         m1_ff   <= (2*C)'(x1) * (2*C)'(y2);
         m2_ff   <= (2*C)'(y1) * (2*C)'(x2);
         m3_ff   <= (2*C)'(x3) * (2*C)'(y4);
         m4_ff   <= (2*C)'(y3) * (2*C)'(x4);
         b1_ff   <= {minmax(x1, x2), minmax(x3, x4), minmax(y1, y2), minmax(y3, y4)};
      end
   end

   // stage 2: determinant and cross terms
   logic signed [2*C+2:0] det2_ff, det3_ff, det4_ff;
   logic signed [2*C:0]   c12_ff, c34_ff;
   logic signed [C:0]     dx12b_ff, dy12b_ff, dx34b_ff, dy34b_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         det2_ff  <= (2*C+3)'(pa_ff) - (2*C+3)'(pb_ff);
         c12_ff   <= (2*C+1)'(m1_ff) - (2*C+1)'(m2_ff);
         c34_ff   <= (2*C+1)'(m3_ff) - (2*C+1)'(m4_ff);
         dx12b_ff <= dx12_ff;
         dy12b_ff <= dy12_ff;
         dx34b_ff <= dx34_ff;
         dy34b_ff <= dy34_ff;
         b2_ff    <= b1_ff;
      end
   end

   // stage 3: numerator products
   logic signed [NW-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff   <= NW'(dx34b_ff) * NW'(c12_ff);
         t2_ff   <= NW'(dx12b_ff) * NW'(c34_ff);
         t3_ff   <= NW'(dy34b_ff) * NW'(c12_ff);
         t4_ff   <= NW'(dy12b_ff) * NW'(c34_ff);
         det3_ff <= det2_ff;
         b3_ff   <= b2_ff;
      end
   end

   // stage 4: numerators
   logic signed [NW-1:0] nx_ff, ny_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff   <= t1_ff - t2_ff;
         ny_ff   <= t3_ff - t4_ff;
         det4_ff <= det3_ff;
         b4_ff   <= b3_ff;
      end
   end

   // stage 5: magnitudes, signs, quotient range check, divider seed
   logic [NW-1:0] nxa, nya;
   logic [2*C+2:0] deta;
   logic [DW-1:0]  dm;
   logic [NM-1:0]  nxm, nym, nxh, nyh;
   logic           dz, sx, sy, sd;
   sipt_flags_type f_ff;
   logic [DW-1:0]  dmag_ff, rx_ff, ry_ff;
   logic [NM-1:0]  nmx_ff, nmy_ff;

   always_comb begin
      sx   = nx_ff[NW-1];
      sy   = ny_ff[NW-1];
      sd   = det4_ff[2*C+2];
      dz   = (det4_ff == '0);
      nxa  = sx ? NW'(-nx_ff) : NW'(nx_ff);
      nya  = sy ? NW'(-ny_ff) : NW'(ny_ff);
      deta = sd ? (2*C+3)'(-det4_ff) : (2*C+3)'(det4_ff);
      dm   = dz ? DW'(1) : deta[DW-1:0];
      nxm  = nxa[NM-1:0];
      nym  = nya[NM-1:0];
      nxh  = nxm >> (C+1);
      nyh  = nym >> (C+1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff.valid <= 1'b0;
      end else if (en) begin
         f_ff.valid <= v_ff[3];
      end
      if (en) begin
         f_ff.det_zero <= dz;
         f_ff.neg_x    <= sx ^ sd;
         f_ff.neg_y    <= sy ^ sd;
         f_ff.ovf_x    <= (nxh >= NM'(dm));
         f_ff.ovf_y    <= (nyh >= NM'(dm));
         dmag_ff       <= dm;
         rx_ff         <= nxh[DW-1:0];
         ry_ff         <= nyh[DW-1:0];
         nmx_ff        <= nxm;
         nmy_ff        <= nym;
         b5_ff         <= b4_ff;
      end
   end

   // valid pipe for stages 1 to 4
   always_comb v_in = {v_ff[2:0], in_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   assign flags  = f_ff;
   assign dmag   = dmag_ff;
   assign rem_x  = rx_ff;
   assign rem_y  = ry_ff;
   assign nmag_x = nmx_ff;
   assign nmag_y = nmy_ff;
   assign bnd    = b5_ff;

endmodule

// File: design/sipt_cell.sv
// One divider cell: develops one quotient bit of both x and y per cycle unless the pipeline stalls.
// Depends on sipt_pkg.
`timescale 1ns / 1ps

module sipt_cell
   import sipt_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16,
   parameter int IDX        = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  sipt_flags_type                       flags_i,
   input  logic [2*COORD_BITS+1:0]              dmag_i,
   input  logic [2*COORD_BITS+1:0]              rem_x_i,
   input  logic [2*COORD_BITS+1:0]              rem_y_i,
   input  logic [3*COORD_BITS+1:0]              nmag_x_i,
   input  logic [3*COORD_BITS+1:0]              nmag_y_i,
   input  logic [COORD_BITS+FRAC_BITS:0]        q_x_i,
   input  logic [COORD_BITS+FRAC_BITS:0]        q_y_i,
   input  logic [8*COORD_BITS-1:0]              bnd_i,
   output sipt_flags_type                       flags_o,
   output logic [2*COORD_BITS+1:0]              dmag_o,
   output logic [2*COORD_BITS+1:0]              rem_x_o,
   output logic [2*COORD_BITS+1:0]              rem_y_o,
   output logic [3*COORD_BITS+1:0]              nmag_x_o,
   output logic [3*COORD_BITS+1:0]              nmag_y_o,
   output logic [COORD_BITS+FRAC_BITS:0]        q_x_o,
   output logic [COORD_BITS+FRAC_BITS:0]        q_y_o,
   output logic [8*COORD_BITS-1:0]              bnd_o
);

   localparam int DW = 2*COORD_BITS+2;
   localparam int QW = COORD_BITS+FRAC_BITS+1;
   localparam int P  = QW-1-IDX;   // dividend bit consumed here

   logic          bx, by;
   logic [DW:0]   tx, ty;
   logic          gx, gy;

   // next dividend bit; the low FRAC_BITS bits of the scaled dividend are zero
   generate
      if (P >= FRAC_BITS) begin : g_bit
         assign bx = nmag_x_i[P-FRAC_BITS];
         assign by = nmag_y_i[P-FRAC_BITS];
      end else begin : g_zero
         assign bx = 1'b0;
         assign by = 1'b0;
      end
   endgenerate

   // restoring compare and subtract
   always_comb begin
      tx = {rem_x_i, bx};
      ty = {rem_y_i, by};
      gx = (tx >= {1'b0, dmag_i});
      gy = (ty >= {1'b0, dmag_i});
   end

   sipt_flags_type flags_ff;
   logic [DW-1:0]  dmag_ff, rx_ff, ry_ff;
   logic [3*COORD_BITS+1:0] nx_ff, ny_ff;
   logic [QW-1:0]  qx_ff, qy_ff;
   logic [8*COORD_BITS-1:0] bnd_ff;

   // valid bit is reset, the datapath is not
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.valid <= 1'b0;
      end else if (en) begin
         flags_ff.valid <= flags_i.valid;
      end
      if (en) begin
         flags_ff.det_zero <= flags_i.det_zero;
         flags_ff.neg_x    <= flags_i.neg_x;
         flags_ff.neg_y    <= flags_i.neg_y;
         flags_ff.ovf_x    <= flags_i.ovf_x;
         flags_ff.ovf_y    <= flags_i.ovf_y;
         dmag_ff <= dmag_i;
         rx_ff   <= gx ? DW'(tx - {1'b0, dmag_i}) : tx[DW-1:0];
         ry_ff   <= gy ? DW'(ty - {1'b0, dmag_i}) : ty[DW-1:0];
         nx_ff   <= nmag_x_i;
         ny_ff   <= nmag_y_i;
         qx_ff   <= {q_x_i[QW-2:0], gx};
         qy_ff   <= {q_y_i[QW-2:0], gy};
         bnd_ff  <= bnd_i;
      end
   end

   assign flags_o  = flags_ff;
   assign dmag_o   = dmag_ff;
   assign rem_x_o  = rx_ff;
   assign rem_y_o  = ry_ff;
   assign nmag_x_o = nx_ff;
   assign nmag_y_o = ny_ff;
   assign q_x_o    = qx_ff;
   assign q_y_o    = qy_ff;
   assign bnd_o    = bnd_ff;

endmodule
